FILE: rtl/hex_code_line_parser_defines.svh
// Assertion macros for the hex code line parser.
// Needs nothing else; included by the modules that check themselves.
`ifndef HEX_CODE_LINE_PARSER_DEFINES_SVH
`define HEX_CODE_LINE_PARSER_DEFINES_SVH

// Plain property, checked at each rising edge outside reset.
`define HCL_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define HCL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HCL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hcl_pkg.sv
// Shared types, character codes and the hex digit decoder of the line parser.
// No dependencies.
`default_nettype none

package hcl_pkg;

  localparam int LineCapDefault = 64;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] code_t;
  typedef logic [3:0]  digits_t;
  typedef logic [5:0]  len_t;

  localparam byte_t ChUpperL = 8'h4C;
  localparam byte_t ChUpperC = 8'h43;
  localparam byte_t ChLowerL = 8'h6C;
  localparam byte_t ChLowerC = 8'h63;
  localparam byte_t ChColon  = 8'h3A;
  localparam byte_t ChCr     = 8'h0D;
  localparam byte_t ChLf     = 8'h0A;

  localparam int PrefixLen  = 3;
  localparam int MinDigits  = 6;
  localparam int MaxDigits  = 8;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_dig_t;

  function automatic hex_dig_t hex_digit(input byte_t c);
    hex_dig_t r;
    r.ok  = 1'b1;
    r.val = 4'h0;
    if (c inside {[8'h30:8'h39]}) begin
      r.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hcl_rx_if.sv
// Byte input channel of the line parser: valid, ready and one received byte.
// Depends on hcl_pkg.
`default_nettype none

interface hcl_rx_if
  import hcl_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/hcl_res_if.sv
// Result channel of the line parser: valid, ready and one line report.
// Depends on hcl_pkg.
`default_nettype none

interface hcl_res_if
  import hcl_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    frame_valid;
  code_t   code_value;
  digits_t digit_count;
  len_t    line_length;

  modport source (output valid, output frame_valid, output code_value,
                  output digit_count, output line_length, input ready);
  modport sink   (input valid, input frame_valid, input code_value,
                  input digit_count, input line_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/hex_code_line_parser.sv
// Hex code line parser top level: checks "LC:" frames byte by byte.
// Depends on hcl_pkg, hcl_rx_if, hcl_res_if and hex_code_line_parser_defines.svh.
//
// Usage:
//   rx_i carries one received byte per beat. CR or LF ends a line; a line
//   with at least one stored character yields one beat on res_o, an empty
//   line yields none. Up to LINE_CAP-1 characters are kept per line, the
//   rest are dropped. A line is a valid frame when it reads "LC:" or "lc:"
//   followed by 6 to 8 hex digits and nothing more.
//   Throughput: one byte per cycle while rx_i.ready is high. The line state is updated in
//   the accepting cycle, and the report of a finished line sits in the
//   result register from the cycle after the CR/LF beat on, with res_o.valid
//   high.
//   Stall: while a report waits and res_o.ready is low, rx_i.ready drops;
//   it stays high whenever the result register is empty or being drained,
//   so bytes keep flowing under a receiver that takes every beat.
//   Reset (rst_ni low, asynchronous): line state cleared, no report pending.
`default_nettype none
`include "hex_code_line_parser_defines.svh"

module hex_code_line_parser
  import hcl_pkg::*;
#(
  parameter int LINE_CAP = LineCapDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hcl_rx_if.sink    rx_i,
  hcl_res_if.source res_o
);

  localparam int CntW = $clog2(LINE_CAP);
  localparam int ExtW = (CntW > 6) ? CntW : 6;

  typedef enum logic [1:0] {
    PFX_NONE  = 2'd0,
    PFX_UPPER = 2'd1,
    PFX_LOWER = 2'd2
  } pfx_e;

  logic [CntW-1:0] line_cnt_q, line_cnt_d;
  pfx_e            pfx_q, pfx_d;
  logic            hex_bad_q, hex_bad_d;
  code_t           hex_val_q, hex_val_d;

  logic    out_valid_q;
  logic    frame_valid_q, frame_valid_d;
  code_t   code_q, code_d;
  digits_t digits_q, digits_d;
  len_t    len_q, len_d;

  logic            in_beat, is_eol, emit, store;
  logic [ExtW-1:0] cnt_ext, cnt_less_pfx;
  hex_dig_t        dig;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign in_beat    = rx_i.valid && rx_i.ready;
  assign is_eol     = (rx_i.rx_byte == ChCr) || (rx_i.rx_byte == ChLf);
  assign cnt_ext    = ExtW'(line_cnt_q);
  assign cnt_less_pfx = cnt_ext - ExtW'(PrefixLen);
  assign emit       = in_beat && is_eol && (line_cnt_q != '0);
  assign store      = in_beat && !is_eol && (line_cnt_q < CntW'(LINE_CAP - 1));
  assign dig        = hex_digit(rx_i.rx_byte);

  always_comb begin
    line_cnt_d    = line_cnt_q;
    pfx_d         = pfx_q;
    hex_bad_d     = hex_bad_q;
    hex_val_d     = hex_val_q;
    frame_valid_d = (pfx_q != PFX_NONE) && !hex_bad_q
                    && (cnt_ext >= ExtW'(PrefixLen + MinDigits))
                    && (cnt_ext <= ExtW'(PrefixLen + MaxDigits));
    code_d        = frame_valid_d ? hex_val_q : '0;
    digits_d      = frame_valid_d ? cnt_less_pfx[3:0] : '0;
    len_d         = cnt_ext[5:0];
    if (in_beat && is_eol) begin
      line_cnt_d = '0;
      pfx_d      = PFX_NONE;
      hex_bad_d  = 1'b0;
      hex_val_d  = '0;
    end else if (store) begin
      line_cnt_d = line_cnt_q + 1'b1;
      if (line_cnt_q == CntW'(0)) begin
        if (rx_i.rx_byte == ChUpperL) begin
          pfx_d = PFX_UPPER;
        end else if (rx_i.rx_byte == ChLowerL) begin
          pfx_d = PFX_LOWER;
        end else begin
          pfx_d = PFX_NONE;
        end
      end else if (line_cnt_q == CntW'(1)) begin
        if (!((pfx_q == PFX_UPPER && rx_i.rx_byte == ChUpperC) ||
              (pfx_q == PFX_LOWER && rx_i.rx_byte == ChLowerC))) begin
          pfx_d = PFX_NONE;
        end
      end else if (line_cnt_q == CntW'(2)) begin
        if (rx_i.rx_byte != ChColon) begin
          pfx_d = PFX_NONE;
        end
      end else if (dig.ok) begin
        hex_val_d = {hex_val_q[27:0], dig.val};
      end else begin
        hex_bad_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q  <= '0;
      pfx_q       <= PFX_NONE;
      hex_bad_q   <= 1'b0;
      hex_val_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      line_cnt_q <= line_cnt_d;
      pfx_q      <= pfx_d;
      hex_bad_q  <= hex_bad_d;
      hex_val_q  <= hex_val_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      frame_valid_q <= frame_valid_d;
      code_q        <= code_d;
      digits_q      <= digits_d;
      len_q         <= len_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.frame_valid = frame_valid_q;
  assign res_o.code_value  = code_q;
  assign res_o.digit_count = digits_q;
  assign res_o.line_length = len_q;

  `HCL_ASSERT(a_cnt_cap, clk_i, rst_ni, line_cnt_q <= CntW'(LINE_CAP - 1), "line count past cap")
  `HCL_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, out_valid_q && !frame_valid_q, code_q == '0 && digits_q == '0, "invalid frame carries data")
  `HCL_ASSERT_IMP(a_good_len, clk_i, rst_ni, out_valid_q && frame_valid_q, (digits_q == 4'd6 || digits_q == 4'd7 || digits_q == 4'd8) && (len_q == 6'(digits_q) + 6'(PrefixLen)), "valid frame length mismatch")
  `HCL_ASSERT_NXT(a_emit, clk_i, rst_ni, emit, out_valid_q && line_cnt_q == '0, "line end lost")

endmodule

`default_nettype wire

FILE: bench/hcl_report_checker.sv
// Line report checker: tracks every accepted byte, works out the report each
// finished line should give, and compares it with the beats on the result channel.
// Depends on hcl_pkg, hcl_rx_if and hcl_res_if.
`default_nettype none

module hcl_report_checker
  import hcl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hcl_rx_if         rx_i,
  hcl_res_if        res_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        reports_seen_o,
  output int        frames_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PfxNone  = 2'd0,
    PfxUpper = 2'd1,
    PfxLower = 2'd2
  } prefix_e;

  typedef struct packed {
    logic    frame_valid;
    code_t   code_value;
    digits_t digit_count;
    len_t    line_length;
  } line_report_t;

  line_report_t expected_reports[$];

  int      chars_held;
  prefix_e prefix_state;
  logic    saw_non_hex;
  code_t   code_acc;

  function automatic logic hex_nibble(input byte_t c, output logic [3:0] nib);
    nib = 4'h0;
    case (c) inside
      [8'h30:8'h39]: nib = 4'(c - 8'h30);
      [8'h41:8'h46]: nib = 4'(c - 8'h41 + 8'd10);
      [8'h61:8'h66]: nib = 4'(c - 8'h61 + 8'd10);
      default:       return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic clear_line();
    chars_held   = 0;
    prefix_state = PfxNone;
    saw_non_hex  = 1'b0;
    code_acc     = '0;
  endtask

  task automatic track_byte(input byte_t c);
    line_report_t rep;
    logic [3:0]   nib;
    if (c == ChCr || c == ChLf) begin
      if (chars_held != 0) begin
        rep.frame_valid = (prefix_state != PfxNone) && !saw_non_hex &&
                          chars_held >= PrefixLen + MinDigits &&
                          chars_held <= PrefixLen + MaxDigits;
        rep.code_value  = rep.frame_valid ? code_acc : '0;
        rep.digit_count = rep.frame_valid ? digits_t'(chars_held - PrefixLen) : '0;
        rep.line_length = len_t'(chars_held);
        expected_reports.push_back(rep);
        clear_line();
      end
    end else if (chars_held < LineCapDefault - 1) begin
      case (chars_held)
        0: begin
          if (c == ChUpperL) prefix_state = PfxUpper;
          else if (c == ChLowerL) prefix_state = PfxLower;
          else prefix_state = PfxNone;
        end
        1: begin
          if (!((prefix_state == PfxUpper && c == ChUpperC) ||
                (prefix_state == PfxLower && c == ChLowerC)))
            prefix_state = PfxNone;
        end
        2: begin
          if (c != ChColon) prefix_state = PfxNone;
        end
        default: begin
          if (hex_nibble(c, nib)) code_acc = {code_acc[27:0], nib};
          else saw_non_hex = 1'b1;
        end
      endcase
      chars_held++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_report_t want;
    int           errs;
    errs = 0;
    if (!rst_ni) begin
      clear_line();
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        reports_seen_o <= reports_seen_o + 1;
        if (res_i.frame_valid) frames_seen_o <= frames_seen_o + 1;
        if (expected_reports.size() == 0) begin
          $error("unexpected report beat: frame_valid %0d code %h len %0d",
                 res_i.frame_valid, res_i.code_value, res_i.line_length);
          errs++;
        end else begin
          want = expected_reports.pop_front();
          if (res_i.frame_valid !== want.frame_valid) begin
            $error("frame_valid: expected %0d, got %0d", want.frame_valid, res_i.frame_valid);
            errs++;
          end
          if (res_i.code_value !== want.code_value) begin
            $error("code_value: expected %h, got %h", want.code_value, res_i.code_value);
            errs++;
          end
          if (res_i.digit_count !== want.digit_count) begin
            $error("digit_count: expected %0d, got %0d", want.digit_count, res_i.digit_count);
            errs++;
          end
          if (res_i.line_length !== want.line_length) begin
            $error("line_length: expected %0d, got %0d", want.line_length, res_i.line_length);
            errs++;
          end
        end
        fail_count_o <= fail_count_o + errs;
      end
      if (rx_i.valid && rx_i.ready) track_byte(rx_i.rx_byte);
      pending_o <= expected_reports.size();
    end
  end

  initial begin
    fail_count_o   = 0;
    pending_o      = 0;
    reports_seen_o = 0;
    frames_seen_o  = 0;
  end

endmodule

`default_nettype wire

FILE: bench/hex_code_line_parser_test.sv
// Top of the line parser bench: clock, reset, byte stimulus and result backpressure.
// Depends on hcl_pkg, the two channel interfaces, hex_code_line_parser and hcl_report_checker.
`default_nettype none

module hex_code_line_parser_test;
  import hcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 400000;
  localparam int BytesPerPhase = 467;

  logic clk_i;
  logic rst_ni;

  hcl_rx_if  rx_bus ();
  hcl_res_if res_bus ();

  int fail_count;
  int pending;
  int reports_seen;
  int frames_seen;

  int src_idle_pct;
  int sink_stall_pct;
  int sent_bytes;
  int long_lines;

  byte_t line_buf[$];

  hex_code_line_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .res_o  (res_bus)
  );

  hcl_report_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_i           (rx_bus),
    .res_i          (res_bus),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .reports_seen_o (reports_seen),
    .frames_seen_o  (frames_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic byte_t hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic byte_t plain_byte();
    byte_t b;
    do b = byte_t'($urandom_range(255)); while (b == ChCr || b == ChLf);
    return b;
  endfunction

  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_bus.ready) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]));
  endtask

  task automatic build_line();
    int  kind;
    int  ndig;
    int  len;
    int  idx;
    bit  upper;
    line_buf.delete();
    kind  = $urandom_range(99);
    upper = $urandom_range(1);
    if (kind < 82) begin
      line_buf.push_back(upper ? ChUpperL : ChLowerL);
      line_buf.push_back(upper ? ChUpperC : ChLowerC);
      line_buf.push_back(ChColon);
      if (kind >= 60 && kind < 72)
        ndig = $urandom_range(1) ? $urandom_range(MinDigits - 1, 0)
                                 : $urandom_range(MaxDigits + 4, MaxDigits + 1);
      else
        ndig = $urandom_range(MaxDigits, MinDigits);
      repeat (ndig) line_buf.push_back(hex_char(4'($urandom_range(15)), $urandom_range(1)));
      if (kind >= 45 && kind < 60) begin
        idx = $urandom_range(PrefixLen - 1);
        line_buf[idx] = $urandom_range(1) ? (line_buf[idx] ^ 8'h20) : plain_byte();
      end else if (kind >= 72) begin
        if ($urandom_range(1)) line_buf.push_back(plain_byte());
        else line_buf[$urandom_range(line_buf.size() - 1, PrefixLen)] = plain_byte();
      end
    end else if (kind < 88) begin
      repeat ($urandom_range(15, 1)) line_buf.push_back(plain_byte());
    end else if (kind >= 93) begin
      long_lines++;
      len = (kind >= 97) ? $urandom_range(LineCapDefault, LineCapDefault - 2)
                         : $urandom_range(90, LineCapDefault + 1);
      line_buf.push_back(upper ? ChUpperL : ChLowerL);
      line_buf.push_back(upper ? ChUpperC : ChLowerC);
      line_buf.push_back(ChColon);
      while (line_buf.size() < len)
        line_buf.push_back(($urandom_range(3) == 0) ? plain_byte()
                           : hex_char(4'($urandom_range(15)), $urandom_range(1)));
    end
    case ($urandom_range(2))
      0: line_buf.push_back(ChCr);
      1: line_buf.push_back(ChLf);
      default: begin
        line_buf.push_back(ChCr);
        line_buf.push_back(ChLf);
      end
    endcase
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int target;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    target = sent_bytes + BytesPerPhase;
    while (sent_bytes < target) begin
      build_line();
      foreach (line_buf[i]) send_byte(line_buf[i]);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    res_bus.ready  = 1'b0;
    src_idle_pct   = 22;
    sink_stall_pct = 84;
    sent_bytes     = 0;
    long_lines     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // max code in mixed-case digits, an empty line, too few digits, a lone NUL
    send_text("LC:FfFfFfFf\r");
    send_text("\n");
    send_text("lc:00000\n");
    send_byte(8'h00);
    send_byte(ChCr);

    run_phase(22, 84);
    run_phase(84, 22);
    run_phase(0, 0);
    rx_bus.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes (%0d overlong-range lines) under three idle/stall mixes.",
             sent_bytes, long_lines);
    $display("Checked %0d line reports, %0d of them valid frames; %0d mismatches.",
             reports_seen, frames_seen, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d reports still expected.", CycleLimit, pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
